// ----- rtl/core/four_level_page_table_walker_macros.svh -----
// Assertion macros for the page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/core/fltw_pkg.sv -----
// Types, constants and helpers shared by the page table walker
`timescale 1ns / 1ps
`default_nettype none
package fltw_pkg;

    localparam int INDEX_BITS = 9;
    localparam int ENTRY_W    = 52;
    localparam int FRAME_W    = 40;
    localparam int FLAGS_W    = 12;
    localparam int VPAGE_W    = 36;

    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NO_PAGE  = 2'd2;

    // present | write | user for a freshly allocated table entry
    localparam logic [FLAGS_W-1:0] TABLE_FLAGS = 12'h007;

    typedef struct packed {
        logic               func;
        logic [VPAGE_W-1:0] virt_page;
        logic [FRAME_W-1:0] phys_frame;
        logic [FLAGS_W-1:0] page_flags;
    } in_req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic [1:0]         status;
    } out_rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } tbl_cmd_t;

    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [VPAGE_W-1:0] vp,
        input logic [1:0]         lvl
    );
        logic [INDEX_BITS-1:0] idx;
        case (lvl)
            2'd3:    idx = vp[35:27];
            2'd2:    idx = vp[26:18];
            2'd1:    idx = vp[17:9];
            default: idx = vp[8:0];
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fltw_table.sv -----
// Table store: single-port synchronous memory with a clearing sweep after reset
`timescale 1ns / 1ps
`default_nettype none
module fltw_table #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  fltw_pkg::tbl_cmd_t       cmd,
    input  wire [ADDR_W-1:0]         addr,
    input  wire [fltw_pkg::ENTRY_W-1:0] wdata,
    output logic [fltw_pkg::ENTRY_W-1:0] rdata,
    output logic                     clearing
);
    import fltw_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]  clr_reg;
    logic               clearing_reg;
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule
`default_nettype wire

// ----- rtl/core/four_level_page_table_walker.sv -----
// Four-level radix page table walker: map and translate over one table store
//
// Request channel (req_valid, req_stall, req): func selects map or translate,
// virt_page gives address bits 47..12, phys_frame and page_flags feed the
// leaf on map. Response channel (rsp_valid, rsp_stall, rsp) returns exactly
// one response per request: frame_out and a status (done, not mapped, no
// free table page).
// One request is walked at a time. Each upper level takes a read of the
// single-port table memory, then the decision and any allocating write; a
// walk can stop early. The response is loaded into the output register when
// the walk ends and that register is free.
// After reset the table memory is swept to zero with req_stall high; the free
// page counter restarts at one (page zero is the root). A stalled response
// sits in the output register; a new request is still taken meanwhile and
// its walk waits at the end for the register.
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_macros.svh"
module four_level_page_table_walker #(
    parameter int TABLE_PAGES = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  fltw_pkg::in_req_t   req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output fltw_pkg::out_rsp_t  rsp
);
    import fltw_pkg::*;

    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = PAGE_W + INDEX_BITS;
    localparam int DEPTH  = TABLE_PAGES * (1 << INDEX_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    in_req_t            req_reg, req_next;
    logic [1:0]         level_reg, level_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    out_rsp_t           res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    out_rsp_t           rsp_reg, rsp_next;

    tbl_cmd_t           cmd;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] entry;
    logic               clearing;

    logic [FRAME_W-1:0] ent_next;
    logic               ent_present;
    logic               ent_oob;
    logic               is_map;
    logic               leaf_write;
    logic               have_free;

    fltw_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .addr     (addr),
        .wdata    (wdata),
        .rdata    (entry),
        .clearing (clearing)
    );

    assign is_map      = (req_reg.func == FUNC_MAP);
    assign ent_present = entry[0];
    assign ent_next    = entry[ENTRY_W-1:FLAGS_W];
    assign ent_oob     = (ent_next >= FRAME_W'(TABLE_PAGES));
    assign have_free   = (free_reg < CNT_W'(TABLE_PAGES));
    assign leaf_write  = (state_reg == S_LOOK) && (level_reg == 2'd0) && is_map;
    assign addr        = {page_reg, level_index(req_reg.virt_page, level_reg)};

    always_comb
    begin
        cmd.rd = (state_reg == S_LOOK) && !leaf_write;
        cmd.wr = leaf_write
                 || ((state_reg == S_EVAL) && is_map && !ent_present && have_free);
        if (leaf_write)
        begin
            wdata = {req_reg.phys_frame, req_reg.page_flags};
        end
        else
        begin
            wdata = {FRAME_W'(free_reg), TABLE_FLAGS};
        end
    end

    assign req_stall = (state_reg != S_IDLE) || clearing;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        level_next     = level_reg;
        page_next      = page_reg;
        free_next      = free_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    req_next   = req;
                    level_next = 2'd3;
                    page_next  = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (leaf_write)
                begin
                    res_next   = '{frame_out: '0, status: ST_DONE};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_LOOK;
                if (level_reg == 2'd0)
                begin
                    if (ent_present)
                    begin
                        res_next = '{frame_out: ent_next, status: ST_DONE};
                    end
                    else
                    begin
                        res_next = '{frame_out: '0, status: ST_UNMAPPED};
                    end
                    state_next = S_DONE;
                end
                else if (ent_present)
                begin
                    level_next = level_reg - 2'd1;
                    if (!ent_oob)
                    begin
                        page_next = ent_next[PAGE_W-1:0];
                    end
                    else if (is_map)
                    begin
                        page_next = '0;
                    end
                    else
                    begin
                        res_next   = '{frame_out: '0, status: ST_UNMAPPED};
                        state_next = S_DONE;
                    end
                end
                else if (!is_map)
                begin
                    res_next   = '{frame_out: '0, status: ST_UNMAPPED};
                    state_next = S_DONE;
                end
                else if (!have_free)
                begin
                    res_next   = '{frame_out: '0, status: ST_NO_PAGE};
                    state_next = S_DONE;
                end
                else
                begin
                    page_next  = free_reg[PAGE_W-1:0];
                    free_next  = free_reg + CNT_W'(1);
                    level_next = level_reg - 2'd1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        level_reg <= level_next;
        page_reg  <= page_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMPL(a_free_bound, clk, rst_n, 1'b1, free_reg <= CNT_W'(TABLE_PAGES))
    `ASSERT_IMPL(a_wr_only_map, clk, rst_n, cmd.wr, is_map && !clearing)
    `ASSERT_IMPL(a_no_rd_clear, clk, rst_n, cmd.rd, !clearing)
    `ASSERT_IMPL(a_frame_done, clk, rst_n,
                 rsp_valid_reg && (rsp_reg.frame_out != '0), rsp_reg.status == ST_DONE)
    `ASSERT_NEXT(a_alloc_bump, clk, rst_n, (state_reg == S_EVAL) && cmd.wr,
                 free_reg == $past(free_reg) + CNT_W'(1))

endmodule
`default_nettype wire
